// ===== design/fsba_pkg.sv =====
package fsba_pkg;

    // Slot map is held as rows of this many used bits
    localparam int ROW_BITS = 32;
    localparam int BIT_W    = 5;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 32;
    localparam int COUNT_W  = 11;

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FREED     = 3'd3,
        ST_OUTSIDE   = 3'd4
    } t_status;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

endpackage

// ===== design/fsba_find.sv =====
module fsba_find #(
    parameter int ROWS  = 32,
    parameter int ROW_W = 5
) (
    input  logic [ROWS-1:0]               i_row_free,
    input  logic [fsba_pkg::ROW_BITS-1:0] i_word,
    output logic                          o_found,
    output logic [ROW_W-1:0]              o_row,
    output logic [fsba_pkg::BIT_W-1:0]    o_bit
);

    // Lowest row with a free slot
    always_comb begin
        o_row = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (i_row_free[r]) begin
                o_row = ROW_W'(r);
            end
        end
    end

    assign o_found = |i_row_free;

    // Lowest clear bit inside the selected row
    always_comb begin
        o_bit = '0;
        for (int b = fsba_pkg::ROW_BITS - 1; b >= 0; b--) begin
            if (!i_word[b]) begin
                o_bit = fsba_pkg::BIT_W'(b);
            end
        end
    end

endmodule

// ===== design/fixed_slot_bitmap_allocator.sv =====
// Fixed-slot pool allocator: SLOT_COUNT slots of SLOT_BYTES bytes starting at
// the pool base written on the configuration channel. A request is taken on
// i_start (o_busy never rises, so one request per clock is accepted) and its
// result passes the input and result registers to the o_ outputs, strobed by
// o_valid for exactly one cycle. The receiver cannot stall: capture every
// result on the cycle o_valid is high. Allocate (mode 0) with a size below
// SLOT_BYTES claims the lowest free slot and returns its address; sizes of
// SLOT_BYTES or more report "too large", and a full pool reports "exhausted".
// Free (mode 1) clears the used bit of the slot containing the address
// (unaligned addresses free their containing slot, freeing an idle slot is
// harmless); addresses outside the pool report "outside". Every result
// carries the free-slot count after the request. Throughput is one item per
// cycle: an input register, then the first-free search, slot decode and map
// update, then the result register. The used map is cleared by reset. Write
// pool_base only while no request is in flight.
module fixed_slot_bitmap_allocator #(
    parameter int SLOT_COUNT = 1024,
    parameter int SLOT_BYTES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_mode,
    input  logic [fsba_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [fsba_pkg::ADDR_W-1:0]   i_free_address,
    // result channel
    output logic                          o_valid,
    output logic [2:0]                    o_status,
    output logic [fsba_pkg::ADDR_W-1:0]   o_slot_address,
    output logic [fsba_pkg::COUNT_W-1:0]  o_free_slot_count,
    // configuration channel (pool_base)
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fsba_pkg::ADDR_W-1:0]   i_cfg_data
);

    localparam int ROW_BITS   = fsba_pkg::ROW_BITS;
    localparam int BIT_W      = fsba_pkg::BIT_W;
    localparam int ROWS       = (SLOT_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W      = ROW_W + BIT_W;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int POOL_BYTES = SLOT_COUNT * SLOT_BYTES;
    localparam int POOL_W     = $clog2(POOL_BYTES);
    // offset / SLOT_BYTES as a multiply by a rounded-up reciprocal; exact for
    // every offset below the pool size (offset * error stays under 2^SHIFT)
    localparam int RECIP_SHIFT = 29;
    localparam longint RECIP  = ((64'd1 << RECIP_SHIFT) + SLOT_BYTES - 1) / SLOT_BYTES;
    localparam int PROD_W     = POOL_W + RECIP_SHIFT + IDX_W;

    // Row reset value: bits past the last real slot read as used forever
    function automatic logic [ROW_BITS-1:0] row_reset(input int row);
        logic [ROW_BITS-1:0] v;
        v = '0;
        for (int b = 0; b < ROW_BITS; b++) begin
            v[b] = ((row * ROW_BITS + b) >= SLOT_COUNT);
        end
        return v;
    endfunction

    // input register
    logic                         r_vld;
    logic                         r_mode;
    logic [fsba_pkg::SIZE_W-1:0]  r_size;
    logic [fsba_pkg::ADDR_W-1:0]  r_addr;

    logic [fsba_pkg::ADDR_W-1:0]  r_pool_base;

    // slot state
    logic [ROW_BITS-1:0]          r_map [ROWS];
    logic [ROWS-1:0]              r_row_free;
    logic [CNT_W-1:0]             r_free_slots;

    // result register
    logic                         r_out_vld;
    fsba_pkg::t_status            r_status;
    logic [fsba_pkg::ADDR_W-1:0]  r_slot_addr;
    logic [fsba_pkg::COUNT_W-1:0] r_count;

    // search and decode
    logic                         find_found;
    logic [ROW_W-1:0]             find_row;
    logic [BIT_W-1:0]             find_bit;
    logic [IDX_W-1:0]             alloc_idx;
    logic [fsba_pkg::ADDR_W-1:0]  offset;
    logic                         in_pool;
    logic [PROD_W-1:0]            div_prod;
    logic [IDX_W-1:0]             free_idx;
    logic [ROW_W-1:0]             free_row;
    logic [BIT_W-1:0]             free_bit;
    logic [ROW_W-1:0]             rd_row;
    logic [ROW_BITS-1:0]          rd_word;

    // next values
    fsba_pkg::t_status            n_status;
    logic [fsba_pkg::ADDR_W-1:0]  n_slot_addr;
    logic [CNT_W-1:0]             n_free_slots;
    logic                         wr_en;
    logic [ROW_BITS-1:0]          wr_word;
    logic                         wr_row_free;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Free path: slot index from the pool offset
    assign offset   = r_addr - r_pool_base;
    assign in_pool  = (offset < fsba_pkg::ADDR_W'(POOL_BYTES));
    assign div_prod = PROD_W'(offset[POOL_W-1:0]) * PROD_W'(RECIP);
    assign free_idx = div_prod[RECIP_SHIFT +: IDX_W];
    assign free_row = free_idx[BIT_W +: ROW_W];
    assign free_bit = free_idx[BIT_W-1:0];

    // One map read per item: the free row, or the first row with room
    assign rd_row  = (r_mode == fsba_pkg::MODE_FREE) ? free_row : find_row;
    assign rd_word = r_map[rd_row];

    fsba_find #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_find (
        .i_row_free (r_row_free),
        .i_word     (rd_word),
        .o_found    (find_found),
        .o_row      (find_row),
        .o_bit      (find_bit)
    );

    assign alloc_idx = {find_row, find_bit};

    always_comb begin
        n_status     = fsba_pkg::ST_FREED;
        n_slot_addr  = '0;
        n_free_slots = r_free_slots;
        wr_en        = 1'b0;
        wr_word      = rd_word;
        wr_row_free  = 1'b1;
        if (r_mode == fsba_pkg::MODE_ALLOC) begin
            if (r_size >= fsba_pkg::SIZE_W'(SLOT_BYTES)) begin
                n_status = fsba_pkg::ST_TOO_LARGE;
            end else if (!find_found) begin
                n_status = fsba_pkg::ST_EXHAUSTED;
            end else begin
                n_status     = fsba_pkg::ST_ALLOCATED;
                wr_en        = r_vld;
                wr_word      = rd_word | (ROW_BITS'(1) << find_bit);
                wr_row_free  = ~&wr_word;
                n_free_slots = r_free_slots - CNT_W'(1);
                n_slot_addr  = r_pool_base
                             + fsba_pkg::ADDR_W'(fsba_pkg::ADDR_W'(alloc_idx)
                                                 * fsba_pkg::ADDR_W'(SLOT_BYTES));
            end
        end else begin
            if (!in_pool) begin
                n_status = fsba_pkg::ST_OUTSIDE;
            end else if (rd_word[free_bit]) begin
                // release only a slot that is actually held
                wr_en        = r_vld;
                wr_word      = rd_word & ~(ROW_BITS'(1) << free_bit);
                wr_row_free  = 1'b1;
                n_free_slots = r_free_slots + CNT_W'(1);
            end
        end
    end

    // Control: input valid, result strobe, pool base, slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= 1'b0;
            r_out_vld    <= 1'b0;
            r_pool_base  <= '0;
            r_free_slots <= CNT_W'(SLOT_COUNT);
            r_row_free   <= '1;
            for (int r = 0; r < ROWS; r++) begin
                r_map[r] <= row_reset(r);
            end
        end else begin
            r_vld     <= i_start;
            r_out_vld <= r_vld;
            if (i_cfg_valid) begin
                r_pool_base <= i_cfg_data;
            end
            if (r_vld) begin
                r_free_slots <= n_free_slots;
            end
            if (wr_en) begin
                r_map[rd_row]      <= wr_word;
                r_row_free[rd_row] <= wr_row_free;
            end
        end
    end

    // Payload: capture request fields, hold result fields
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= i_mode;
            r_size <= i_request_size;
            r_addr <= i_free_address;
        end
        if (r_vld) begin
            r_status    <= n_status;
            r_slot_addr <= n_slot_addr;
            r_count     <= fsba_pkg::COUNT_W'(n_free_slots);
        end
    end

    assign o_valid           = r_out_vld;
    assign o_status          = r_status;
    assign o_slot_address    = r_slot_addr;
    assign o_free_slot_count = r_count;

endmodule

// ===== design/fsba_chk.sv =====
module fsba_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_valid,
    input logic [2:0]                    o_status,
    input logic [fsba_pkg::ADDR_W-1:0]   o_slot_address,
    input logic [fsba_pkg::COUNT_W-1:0]  o_free_slot_count
);

    // Every accepted item yields one result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("result missing for accepted item");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |=> ##1 !o_valid)
        else $error("result without accepted item");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != fsba_pkg::ST_ALLOCATED)) |-> (o_slot_address == '0))
        else $error("slot address set on non-allocate result");

    a_exhausted_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == fsba_pkg::ST_EXHAUSTED)) |-> (o_free_slot_count == '0))
        else $error("pool reported exhausted with free slots");

    // Back-to-back allocations drop the free count by one each
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == fsba_pkg::ST_ALLOCATED)
         && $past(o_valid) && ($past(o_status) == fsba_pkg::ST_ALLOCATED))
        |-> (o_free_slot_count
             == fsba_pkg::COUNT_W'($past(o_free_slot_count) - fsba_pkg::COUNT_W'(1))))
        else $error("free count not decremented on allocate");

endmodule

bind fixed_slot_bitmap_allocator fsba_chk u_fsba_chk (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

// Check the fixed-slot pool allocator against a cycle-free model of its used
// map. Every accepted request is applied to the model at the accepting edge.
// The reply that the model computes is queued, and each strobed result is
// compared field by field with the oldest queued reply. The run covers:
// - a short directed set of requests at the field extremes
// - a fill of the pool up to exhaustion, with the pool wrapping past address 0
// - mixed random traffic under two pool bases
// - a final stretch with no idle cycles
module testbench;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_BYTES = 32;
    localparam logic [fsba_pkg::ADDR_W-1:0] POOL_BYTES = SLOT_COUNT * SLOT_BYTES;

    // Margin of idle clocks left after the last reply comes back
    localparam int DRAIN_CYCLES   = 4;
    // Longest correct quiet stretch is an idle burst or the reset
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        fsba_pkg::t_status              status;
        logic [fsba_pkg::ADDR_W-1:0]    slot_address;
        logic [fsba_pkg::COUNT_W-1:0]   free_slot_count;
    } t_pool_reply;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_start = 1'b0;
    logic                           o_busy;
    logic                           i_mode = fsba_pkg::MODE_ALLOC;
    logic [fsba_pkg::SIZE_W-1:0]    i_request_size = '0;
    logic [fsba_pkg::ADDR_W-1:0]    i_free_address = '0;
    logic                           o_valid;
    logic [2:0]                     o_status;
    logic [fsba_pkg::ADDR_W-1:0]    o_slot_address;
    logic [fsba_pkg::COUNT_W-1:0]   o_free_slot_count;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [fsba_pkg::ADDR_W-1:0]    i_cfg_data = '0;

    // Model of the pool: used map, free count and the current base
    bit                             slot_taken [SLOT_COUNT];
    int unsigned                    free_slots_left = SLOT_COUNT;
    logic [fsba_pkg::ADDR_W-1:0]    pool_base_now = '0;

    // Replies owed by the allocator, oldest first
    t_pool_reply                    pool_replies_due [$];

    int                             error_count = 0;
    int                             exhausted_replies = 0;
    int                             idle_pct = 0;
    int                             quiet_cycles = 0;

    fixed_slot_bitmap_allocator #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_mode            (i_mode),
        .i_request_size    (i_request_size),
        .i_free_address    (i_free_address),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_slot_address    (o_slot_address),
        .o_free_slot_count (o_free_slot_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Apply one request to the pool model and return the reply it must produce
    function automatic t_pool_reply pool_apply_request(logic mode,
                                                       logic [fsba_pkg::SIZE_W-1:0] size,
                                                       logic [fsba_pkg::ADDR_W-1:0] addr);
        t_pool_reply                 reply;
        logic [fsba_pkg::ADDR_W-1:0] offset;
        int                          slot;
        bit                          claimed;
        reply.status       = fsba_pkg::ST_FREED;
        reply.slot_address = '0;
        claimed            = 1'b0;
        if (mode == fsba_pkg::MODE_ALLOC) begin
            if (size >= SLOT_BYTES) begin
                reply.status = fsba_pkg::ST_TOO_LARGE;
            end else begin
                // First fit: claim the lowest free slot
                for (slot = 0; slot < SLOT_COUNT; slot++) begin
                    if (!claimed && !slot_taken[slot]) begin
                        claimed            = 1'b1;
                        slot_taken[slot]   = 1'b1;
                        free_slots_left--;
                        reply.status       = fsba_pkg::ST_ALLOCATED;
                        reply.slot_address = pool_base_now
                                           + fsba_pkg::ADDR_W'(slot * SLOT_BYTES);
                    end
                end
                if (!claimed) begin
                    reply.status = fsba_pkg::ST_EXHAUSTED;
                    exhausted_replies++;
                end
            end
        end else begin
            // Membership is taken mod 2^32, so a pool near the top wraps to 0
            offset = addr - pool_base_now;
            if (offset >= POOL_BYTES) begin
                reply.status = fsba_pkg::ST_OUTSIDE;
            end else begin
                // Unaligned addresses free the slot that contains them
                slot = int'(offset / SLOT_BYTES);
                if (slot_taken[slot]) begin
                    slot_taken[slot] = 1'b0;
                    free_slots_left++;
                end
            end
        end
        reply.free_slot_count = free_slots_left[fsba_pkg::COUNT_W-1:0];
        return reply;
    endfunction

    // Scan forward (with wrap) from a random start for a slot that is in use
    function automatic int pick_taken_slot(int from);
        int k;
        int slot;
        int found;
        found = from;
        for (k = SLOT_COUNT - 1; k >= 0; k--) begin
            slot = (from + k) % SLOT_COUNT;
            if (slot_taken[slot]) found = slot;
        end
        return found;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] expected, logic [31:0] actual);
        error_count++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, expected, actual);
    endtask

    // Pop the oldest reply due for every strobed result and compare its fields
    always @(posedge i_clk) begin : check_replies
        t_pool_reply due;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pool_replies_due.size() == 0) begin
                report_mismatch("unrequested result status", '0, o_status);
            end else begin
                due = pool_replies_due.pop_front();
                if (o_status !== due.status)
                    report_mismatch("status", due.status, o_status);
                if (o_slot_address !== due.slot_address)
                    report_mismatch("slot_address", due.slot_address, o_slot_address);
                if (o_free_slot_count !== due.free_slot_count)
                    report_mismatch("free_slot_count", due.free_slot_count, o_free_slot_count);
            end
        end
    end

    // Count cycles in which nothing moves on any channel; stop a hung run
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item from a falling edge and hold it until accepted.
    // Leave i_start high on return so the next item can follow back to back.
    task automatic send_request(logic mode, logic [fsba_pkg::SIZE_W-1:0] size,
                                logic [fsba_pkg::ADDR_W-1:0] addr);
        i_start        <= 1'b1;
        i_mode         <= mode;
        i_request_size <= size;
        i_free_address <= addr;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        pool_replies_due.push_back(pool_apply_request(mode, size, addr));
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        i_start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Stop sending and wait until every reply due has come back
    task automatic drain_requests();
        i_start <= 1'b0;
        while (pool_replies_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Move the pool only with the pipeline empty
    task automatic write_pool_base(logic [fsba_pkg::ADDR_W-1:0] base);
        drain_requests();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        pool_base_now = base;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Insert an idle burst now and then; every 50 items reroll whether bursts happen
    task automatic pace_sender(int idx, bit with_idling);
        if (idx % 50 == 0)
            idle_pct = (with_idling && $urandom_range(0, 2) != 0) ? 30 : 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            idle_cycles($urandom_range(1, 11));
    endtask

    // One random request: mostly well-formed allocates and frees of slots in use,
    // with some oversized allocates, frees of idle slots and frees outside the pool
    task automatic random_request(int alloc_pct);
        logic [fsba_pkg::SIZE_W-1:0] size;
        logic [fsba_pkg::ADDR_W-1:0] addr;
        int                          pick;
        size = $urandom;
        addr = $urandom;
        if ($urandom_range(0, 99) < alloc_pct) begin
            if ($urandom_range(0, 19) != 0)
                size = $urandom_range(0, SLOT_BYTES - 1);
            else if (size < SLOT_BYTES)
                size = size | SLOT_BYTES;
            send_request(fsba_pkg::MODE_ALLOC, size, addr);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                addr = pool_base_now
                     + fsba_pkg::ADDR_W'(pick_taken_slot($urandom_range(0, SLOT_COUNT - 1))
                                         * SLOT_BYTES)
                     + $urandom_range(0, SLOT_BYTES - 1);
            else if (pick == 7)
                addr = pool_base_now + $urandom_range(0, POOL_BYTES - 1);
            else
                addr = pool_base_now + POOL_BYTES
                     + $urandom_range(0, 32'hFFFF_FFFF - POOL_BYTES);
            send_request(fsba_pkg::MODE_FREE, size, addr);
        end
    endtask

    // Field extremes and the corner cases, starting from the reset pool at 0
    task automatic test_directed_cases();
        send_request(fsba_pkg::MODE_ALLOC, 32'd32, 32'h0);         // exactly the slot size
        send_request(fsba_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'h0);  // largest size
        send_request(fsba_pkg::MODE_FREE, 32'h0, POOL_BYTES);      // first byte past the pool
        send_request(fsba_pkg::MODE_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(fsba_pkg::MODE_FREE, 32'h0, 32'd160);         // slot that was never taken
        send_request(fsba_pkg::MODE_ALLOC, 32'd0, 32'h0);          // zero size still claims a slot
        send_request(fsba_pkg::MODE_ALLOC, 32'd31, 32'h0);         // largest size that fits
        send_request(fsba_pkg::MODE_ALLOC, 32'd16, 32'hFFFF_FFFF); // free address ignored here
        send_request(fsba_pkg::MODE_FREE, 32'h0, 32'd33);          // unaligned: frees slot 1
        send_request(fsba_pkg::MODE_ALLOC, 32'd5, 32'h0);          // first fit takes slot 1 back
        send_request(fsba_pkg::MODE_FREE, 32'hFFFF_FFFF, 32'h0);   // size ignored on free
        send_request(fsba_pkg::MODE_FREE, 32'h0, 32'h0);           // free the same slot twice
        send_request(fsba_pkg::MODE_FREE, 32'h0, POOL_BYTES - 1);  // last byte of the pool
        // Pool near the top of the address space wraps round through 0
        write_pool_base(32'hFFFF_F000);
        send_request(fsba_pkg::MODE_ALLOC, 32'd1, 32'h0);
        send_request(fsba_pkg::MODE_FREE, 32'h0, 32'hFFFF_F040);
        send_request(fsba_pkg::MODE_FREE, 32'h0, 32'h0000_0000);   // wrapped slot 128
        send_request(fsba_pkg::MODE_FREE, 32'h0, 32'h0000_7000);   // just past the wrapped end
        send_request(fsba_pkg::MODE_FREE, 32'h0, 32'hFFFF_EFFF);   // just below the base
    endtask

    // Allocate until the pool runs dry a few times over
    task automatic test_fill_to_exhaustion();
        int idx;
        idx = 0;
        while (exhausted_replies < 3) begin
            pace_sender(idx, 1'b1);
            random_request(100);
            idx++;
        end
    endtask

    task automatic test_random_traffic(int count, int alloc_pct);
        int idx;
        for (idx = 0; idx < count; idx++) begin
            pace_sender(idx, 1'b1);
            random_request(alloc_pct);
        end
    endtask

    task automatic test_back_to_back(int count);
        int idx;
        for (idx = 0; idx < count; idx++) random_request(50);
    endtask

    initial begin
        // Synchronous reset, held low from the start and released at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_fill_to_exhaustion();

        write_pool_base(32'hFFFF_FFFF);
        test_random_traffic(60, 30);

        write_pool_base($urandom & 32'hFFFF_F000);
        test_random_traffic(60, 60);

        write_pool_base(32'h0);
        test_back_to_back(60);

        drain_requests();
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/fsba_pkg.sv
design/fsba_find.sv
design/fixed_slot_bitmap_allocator.sv
design/fsba_chk.sv
test/testbench.sv
